// ===== src/ssq_pkg.sv =====
package ssq_pkg;

  // Default number of queue entries.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned US_PER_SECOND = 1000000;
  localparam int unsigned US_W          = 20;
  localparam int unsigned SECS_W        = 31;
  localparam int unsigned PROD_W        = SECS_W + US_W;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned ID_W          = 16;

  typedef enum logic {
    OP_SLEEP = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic {
    KIND_ANSWER = 1'b0,
    KIND_WOKEN  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_ADD   = 6'b000100,
    S_INS   = 6'b001000,
    S_ANS   = 6'b010000,
    S_DRAIN = 6'b100000
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic add;
    logic insert;
    logic load_answer;
    logic pop;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic reject;
    logic out_free;
    logic head_due;
    logic next_due;
  } stat_t;

endpackage

// ===== src/ssq_ctrl.sv =====
module ssq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssq_pkg::stat_t stat_i,
  output ssq_pkg::cmd_t  cmd_o
);
  import ssq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.is_tick) begin
            state_d = S_DRAIN;
          end else if (stat_i.reject) begin
            state_d = S_ANS;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_INS;
      end
      S_INS: begin
        cmd_o.insert = 1'b1;
        state_d      = S_IDLE;
      end
      S_ANS: begin
        if (stat_i.out_free) begin
          cmd_o.load_answer = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_DRAIN: begin
        // Sorted queue: due entries form a prefix, so pop heads until one is not due.
        if (!stat_i.head_due) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (!stat_i.next_due) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/ssq_datapath.sv =====
module ssq_datapath #(
  parameter int unsigned QUEUE_DEPTH = ssq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_i,
  input  logic [15:0]   proc_id_i,
  input  logic signed [31:0] sleep_seconds_i,
  input  logic [31:0]   now_us_i,
  input  logic          out_ready_i,
  input  ssq_pkg::cmd_t  cmd_i,
  output ssq_pkg::stat_t stat_o,
  output logic          out_valid_o,
  output logic          kind_o,
  output logic [1:0]    status_o,
  output logic [15:0]   woken_id_o,
  output logic          last_o
);
  import ssq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [US_W-1:0] US_C = US_W'(US_PER_SECOND);

  logic [ID_W-1:0]   pid_q;
  logic [SECS_W-1:0] secs_q;
  logic [TIME_W-1:0] now_q;
  status_e           ans_q;
  logic [PROD_W-1:0] prod_q;
  logic [TIME_W-1:0] wake_q;
  logic [PROD_W:0]   sum;

  logic [TIME_W-1:0] wake_mem_q [QUEUE_DEPTH];
  logic [ID_W-1:0]   id_mem_q   [QUEUE_DEPTH];
  logic [CW-1:0]     count_q;
  logic [QUEUE_DEPTH-1:0] keep;

  logic              out_valid_q;
  kind_e             kind_q;
  status_e           status_q;
  logic [ID_W-1:0]   woken_q;
  logic              last_q;

  logic req_neg, req_zero, full;

  assign req_neg  = sleep_seconds_i[31];
  assign req_zero = (sleep_seconds_i == '0);
  assign full     = (count_q == CW'(QUEUE_DEPTH));

  assign stat_o.is_tick  = (op_i == OP_TICK);
  assign stat_o.reject   = req_neg | req_zero | full;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.head_due = (count_q != '0) && (wake_mem_q[0] <= now_q);
  assign stat_o.next_due = (count_q > CW'(1)) && (wake_mem_q[1] <= now_q);

  assign sum = {{(PROD_W + 1 - TIME_W){1'b0}}, now_q} + {1'b0, prod_q};

  // Entries at or before the new wake time stay; equal times keep arrival order.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (CW'(i) < count_q) && (wake_mem_q[i] <= wake_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pid_q  <= proc_id_i;
      secs_q <= sleep_seconds_i[SECS_W-1:0];
      now_q  <= now_us_i;
      if (req_neg) begin
        ans_q <= ST_NEG;
      end else if (req_zero) begin
        ans_q <= ST_OK;
      end else begin
        ans_q <= ST_FULL;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(secs_q) * PROD_W'(US_C);
    end
    if (cmd_i.add) begin
      // Saturate to the largest 32-bit time.
      wake_q <= (sum[PROD_W:TIME_W] != '0) ? '1 : sum[TIME_W-1:0];
    end
    if (cmd_i.insert) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!keep[i]) begin
          if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
            wake_mem_q[i] <= wake_q;
            id_mem_q[i]   <= pid_q;
          end else begin
            wake_mem_q[i] <= wake_mem_q[(i == 0) ? 0 : i - 1];
            id_mem_q[i]   <= id_mem_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        wake_mem_q[i] <= wake_mem_q[i + 1];
        id_mem_q[i]   <= id_mem_q[i + 1];
      end
    end
    if (cmd_i.load_answer) begin
      kind_q   <= KIND_ANSWER;
      status_q <= ans_q;
      woken_q  <= pid_q;
      last_q   <= 1'b1;
    end else if (cmd_i.pop) begin
      kind_q   <= KIND_WOKEN;
      status_q <= ST_OK;
      woken_q  <= id_mem_q[0];
      last_q   <= !stat_o.next_due;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.insert) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.load_answer || cmd_i.pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign status_o    = status_q;
  assign woken_id_o  = woken_q;
  assign last_o      = last_q;

endmodule

// ===== src/sorted_sleep_timer_queue.sv =====
// Sorted sleep timer queue.
// Input channel (in_valid_i/in_ready_o) takes one request: op_i selects a
// sleep request (proc_id_i, sleep_seconds_i, now_us_i) or a clock tick
// (now_us_i only). Output channel (out_valid_o/out_ready_i) delivers results
// with kind_o, status_o, woken_id_o and last_o.
// A sleep with negative or zero seconds, or into a full queue, is answered
// once (last_o high) when the output register is free. A valid sleep gives
// no result and occupies the block for capture, multiply by one million, add
// and saturate, then a parallel compare-and-shift insert across all
// entries. A tick pops due entries from the head, oldest wake time first, one
// per cycle while the output register is free, marking the final one with
// last_o; a tick that wakes nothing returns to idle. One request is in work
// at a time. Results sit in one output register; while out_valid_o is high
// and out_ready_i is low the result holds and the block waits. Reset empties
// the queue and drops any pending result; entry contents need no clearing.
module sorted_sleep_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = ssq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [15:0] proc_id_i,
  input  logic signed [31:0] sleep_seconds_i,
  input  logic [31:0] now_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [1:0]  status_o,
  output logic [15:0] woken_id_o,
  output logic        last_o
);
  import ssq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request through its steps.
  ssq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the sorted entries, wake arithmetic and the output register.
  ssq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_i),
    .proc_id_i       (proc_id_i),
    .sleep_seconds_i (sleep_seconds_i),
    .now_us_i        (now_us_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .woken_id_o      (woken_id_o),
    .last_o          (last_o)
  );

endmodule

// ===== src/ssq_checker.sv =====
module ssq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        op_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        kind_o,
  input logic [1:0]  status_o,
  input logic [15:0] woken_id_o,
  input logic        last_o
);
  import ssq_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(woken_id_o) && $stable(kind_o))
    else $error("stalled result changed");

  // Only one request is in work at a time.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // An answer to a sleep is always the only result of its request.
  a_answer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ANSWER) |-> last_o)
    else $error("answer not marked last");

  // Woken results carry ok status.
  a_woken_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_WOKEN) |-> (status_o == ST_OK))
    else $error("woken result with error status");

  // Status never shows an unused code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_NEG) || (status_o == ST_FULL))
    else $error("bad status code");

endmodule

bind sorted_sleep_timer_queue ssq_checker u_ssq_checker (.*);

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssq_pkg::*;

  localparam int unsigned DEPTH            = QUEUE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT      = 5000;
  localparam int unsigned SETTLE_CYCLES    = 24;
  localparam int unsigned RANDOM_PER_PHASE = 75;
  localparam logic [31:0] TIME_MAX         = 32'hFFFF_FFFF;

  // One result as it should leave the output channel.
  typedef struct {
    kind_e       kind;
    status_e     status;
    logic [15:0] pid;
    logic        last;
  } result_t;

  // Sleeper list kept in wake order, plus the results still owed by the block.
  class wake_schedule;
    logic [31:0] wake_at[$];
    logic [15:0] sleeper[$];
    result_t     owed[$];
    int unsigned mismatches;
    int unsigned sleeps;
    int unsigned ticks;
    int unsigned results_seen;
    int unsigned peak_fill;

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    function void answer(status_e st, logic [15:0] pid);
      result_t r;
      r.kind   = KIND_ANSWER;
      r.status = st;
      r.pid    = pid;
      r.last   = 1'b1;
      owed.push_back(r);
    endfunction

    // Apply one accepted request and queue whatever it must produce.
    function void note_request(op_e op, logic [15:0] pid, logic [31:0] secs,
                               logic [31:0] now);
      logic [63:0] wake;
      int unsigned pos;
      int unsigned woke;
      logic [31:0] kept_at[$];
      logic [15:0] kept_id[$];
      result_t     r;
      if (op == OP_SLEEP) begin
        sleeps++;
        if (secs[31]) begin
          answer(ST_NEG, pid);
        end else if (secs == 32'd0) begin
          answer(ST_OK, pid);
        end else if (wake_at.size() >= DEPTH) begin
          answer(ST_FULL, pid);
        end else begin
          wake = 64'(now) + 64'(secs) * 64'(US_PER_SECOND);
          if (wake > 64'(TIME_MAX)) wake = 64'(TIME_MAX);
          // Equal wake times keep arrival order: step past every entry <= wake.
          pos = 0;
          while (pos < wake_at.size() && wake_at[pos] <= wake[31:0]) pos++;
          wake_at.insert(pos, wake[31:0]);
          sleeper.insert(pos, pid);
          if (wake_at.size() > peak_fill) peak_fill = wake_at.size();
        end
      end else begin
        ticks++;
        woke = 0;
        foreach (wake_at[i]) begin
          if (wake_at[i] <= now) begin
            r.kind   = KIND_WOKEN;
            r.status = ST_OK;
            r.pid    = sleeper[i];
            r.last   = 1'b0;
            owed.push_back(r);
            woke++;
          end else begin
            kept_at.push_back(wake_at[i]);
            kept_id.push_back(sleeper[i]);
          end
        end
        if (woke > 0) begin
          r = owed.pop_back();
          r.last = 1'b1;
          owed.push_back(r);
        end
        wake_at = kept_at;
        sleeper = kept_id;
      end
    endfunction

    function void check_result(logic kind, logic [1:0] status, logic [15:0] pid,
                               logic last);
      result_t e;
      results_seen++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result kind=%0d status=%0d id=%h last=%0d",
                         kind, status, pid, last));
        return;
      end
      e = owed.pop_front();
      if (kind !== e.kind || status !== e.status || pid !== e.pid || last !== e.last)
        report($sformatf("expected kind=%0d status=%0d id=%h last=%0d, got %0d %0d %h %0d",
                         e.kind, e.status, e.pid, e.last, kind, status, pid, last));
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic        op_i            = 1'b0;
  logic [15:0] proc_id_i       = '0;
  logic [31:0] sleep_seconds_i = '0;
  logic [31:0] now_us_i        = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        kind_o;
  logic [1:0]  status_o;
  logic [15:0] woken_id_o;
  logic        last_o;

  // Idle and stall odds in percent; the receiver odds change only by NBA so
  // the ready generator never races the phase switch.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned quiet_cycles    = 0;
  logic [31:0] clock_us        = '0;

  wake_schedule sb;

  sorted_sleep_timer_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .proc_id_i      (proc_id_i),
    .sleep_seconds_i(sleep_seconds_i),
    .now_us_i       (now_us_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .woken_id_o     (woken_id_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: drop ready at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result on the edge where it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(kind_o, status_o, woken_id_o, last_o);
  end

  // Watchdog: abort when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one request, optionally after a random idle gap, and hold it until
  // taken. Called on a rising edge; returns on the accepting edge with valid
  // still high, so back-to-back requests never toggle valid within a step.
  task automatic send_request(op_e op, logic [15:0] pid, logic [31:0] secs,
                              logic [31:0] now);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    proc_id_i       <= pid;
    sleep_seconds_i <= secs;
    now_us_i        <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, pid, secs, now);
  endtask

  // Mostly a coherent timeline: sleeps at the current time, ticks that move
  // time forward by up to three seconds. Mix in fully random requests too.
  task automatic random_request();
    int unsigned pick;
    logic [31:0] secs;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_request(op_e'($urandom_range(1)), 16'($urandom), $urandom, $urandom);
    end else if (pick < 60) begin
      secs = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
      send_request(OP_SLEEP, 16'($urandom), secs, clock_us);
    end else begin
      clock_us += $urandom_range(3_000_000);
      send_request(OP_TICK, 16'($urandom), $urandom, clock_us);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under light pressure on both sides.
    sender_idle_pct = 18;
    recv_stall_pct <= 18;
    send_request(OP_SLEEP, 16'hFFFF, 32'h8000_0000, 32'd0);   // most negative seconds
    send_request(OP_SLEEP, 16'h0000, 32'hFFFF_FFFF, 32'd0);   // minus one second
    send_request(OP_SLEEP, 16'h1234, 32'd0, 32'd0);           // zero seconds
    send_request(OP_TICK, 16'h0000, 32'd0, TIME_MAX);         // tick on an empty queue
    send_request(OP_SLEEP, 16'h0001, 32'h7FFF_FFFF, 32'd0);   // product too large, wake saturates
    send_request(OP_SLEEP, 16'h0002, 32'd1, TIME_MAX);        // sum saturates
    send_request(OP_SLEEP, 16'h0003, 32'd2, 32'd5);
    send_request(OP_SLEEP, 16'h0004, 32'd2, 32'd5);           // equal wake, stays behind
    send_request(OP_SLEEP, 16'h0005, 32'd1, 32'd5);           // earlier wake, moves ahead
    for (int i = 0; i < 11; i++)
      send_request(OP_SLEEP, 16'(16'h0100 + i), 32'(1 + i % 3), 32'd5);
    send_request(OP_SLEEP, 16'hBEEF, 32'd1, 32'd5);           // queue full
    send_request(OP_TICK, 16'h0000, 32'd0, 32'd1_000_004);    // one short of the first wake
    send_request(OP_TICK, 16'h0000, 32'd0, TIME_MAX);         // drain all sixteen

    // Random requests over four pressure phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 59;
          recv_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct <= 59;
        end
        default: begin
          sender_idle_pct = 18;
          recv_stall_pct <= 18;
        end
      endcase
      repeat (RANDOM_PER_PHASE) random_request();
    end
    in_valid_i <= 1'b0;

    // Wait out every owed result, then give stragglers a chance to show up.
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.owed.size()));

    $display("Run covered %0d sleep requests and %0d ticks across four pressure phases.",
             sb.sleeps, sb.ticks);
    $display("Checked %0d results; queue peaked at %0d of %0d entries; %0d mismatches.",
             sb.results_seen, sb.peak_fill, DEPTH, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ssq_pkg.sv
src/ssq_ctrl.sv
src/ssq_datapath.sv
src/sorted_sleep_timer_queue.sv
src/ssq_checker.sv
test/testbench.sv
